// ----- hw/rtl/sqpi_pkg.sv -----
// ----------------------------------------------------------------------------
// sqpi_pkg
// Shared types and constants for the shifting queue with position insert.
// ----------------------------------------------------------------------------
package sqpi_pkg;

   localparam int DEPTH_DEF       = 16;
   localparam int ENTRY_WIDTH_DEF = 32;

   localparam int CMD_W      = 2;
   localparam int DATA_W     = 32;
   localparam int POSITION_W = 5;
   localparam int STATUS_W   = 2;
   localparam int FILL_W     = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_INSERT  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // per-cycle action broadcast to every cell
   typedef struct packed {
      logic put;   // place new entry at put index, later cells take from previous
      logic take;  // every cell takes from the next one
   } cell_ctrl_type;

endpackage

// ----- hw/rtl/sqpi_req_if.sv -----
// ----------------------------------------------------------------------------
// sqpi_req_if
// Command channel: valid/ready handshake with command, entry and position.
// ----------------------------------------------------------------------------
interface sqpi_req_if import sqpi_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      cmd;
   logic [DATA_W-1:0]     entry_data;
   logic [POSITION_W-1:0] position;

   modport source (output valid, output cmd, output entry_data, output position,
                   input ready);
   modport sink   (input valid, input cmd, input entry_data, input position,
                   output ready);

endinterface

// ----- hw/rtl/sqpi_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sqpi_rsp_if
// Result channel: valid/ready handshake with status, removed entry and fill.
// ----------------------------------------------------------------------------
interface sqpi_rsp_if import sqpi_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DATA_W-1:0]   removed_data;
   logic [FILL_W-1:0]   fill_count;

   modport source (output valid, output status, output removed_data,
                   output fill_count, input ready);
   modport sink   (input valid, input status, input removed_data,
                   input fill_count, output ready);

endinterface

// ----- hw/rtl/sqpi_cell.sv -----
// ----------------------------------------------------------------------------
// sqpi_cell
// One queue slot: holds, loads a new entry, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module sqpi_cell import sqpi_pkg::*; #(
   parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF,
   parameter int IDX_W       = 4,
   parameter int INDEX       = 0
) (
   input  logic                   clock,
   input  cell_ctrl_type          ctrl,
   input  logic [IDX_W-1:0]       put_idx,
   input  logic [ENTRY_WIDTH-1:0] new_entry,
   input  logic [ENTRY_WIDTH-1:0] prev_entry,
   input  logic [ENTRY_WIDTH-1:0] next_entry,
   output logic [ENTRY_WIDTH-1:0] entry
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [ENTRY_WIDTH-1:0] entry_ff;
   logic [ENTRY_WIDTH-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.put) begin
         if (put_idx == MY_IDX) begin
            entry_in = new_entry;
         end else if (put_idx < MY_IDX) begin
            entry_in = prev_entry;
         end
      end else if (ctrl.take) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ----- hw/rtl/shifting_queue_with_position_insert.sv -----
// The result of a command is registered and presented in the cycle after its transfer.
// Throughput: one command per cycle unless a held result stalls the command channel; all cells shift in parallel.
// A new command is taken while the result register drains in the same cycle.
// Reset: synchronous; empties the queue and drops any pending result.
// Slot contents are not cleared; only slots below the fill count are read.
// ----------------------------------------------------------------------------
// shifting_queue_with_position_insert
// Queue with head at slot 0: enqueue, dequeue and positional insert.
// ----------------------------------------------------------------------------
module shifting_queue_with_position_insert import sqpi_pkg::*; #(
   parameter int DEPTH       = DEPTH_DEF,
   parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   sqpi_req_if.sink          req_chan,
   sqpi_rsp_if.source        rsp_chan
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (OCC_W > POSITION_W) ? OCC_W : POSITION_W;

   logic [OCC_W-1:0]       occ_ff;
   logic [OCC_W-1:0]       occ_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [STATUS_W-1:0]    rsp_status_in;
   logic [DATA_W-1:0]      rsp_removed_ff;
   logic [DATA_W-1:0]      rsp_removed_in;
   logic [FILL_W-1:0]      rsp_fill_ff;
   logic [FILL_W-1:0]      rsp_fill_in;

   logic                   req_fire;
   cell_ctrl_type          ctrl;
   logic [IDX_W-1:0]       put_idx;
   logic [ENTRY_WIDTH-1:0] new_entry;
   logic [ENTRY_WIDTH-1:0] cell_entry [DEPTH];
   logic [POSITION_W-1:0]  pos_zb;
   logic                   pos_inside;
   logic                   is_full;
   logic                   no_entries;
   status_type             status;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign new_entry      = ENTRY_WIDTH'(req_chan.entry_data);
   assign is_full        = (occ_ff == OCC_W'(DEPTH));
   assign no_entries     = (occ_ff == '0);

   // 1-based position, zero treated as the head
   assign pos_zb     = (req_chan.position == '0) ? '0 : req_chan.position - 1'b1;
   assign pos_inside = CMP_W'(pos_zb) < CMP_W'(occ_ff);

   always_comb begin
      ctrl    = '0;
      status  = ST_DONE;
      occ_in  = occ_ff;
      put_idx = IDX_W'(occ_ff);
      case (cmd_type'(req_chan.cmd))
         CMD_ENQUEUE, CMD_INSERT: begin
            if (is_full) begin
               status = ST_FULL;
            end else begin
               ctrl.put = req_fire;
               occ_in   = occ_ff + 1'b1;
               if (cmd_type'(req_chan.cmd) == CMD_INSERT && pos_inside) begin
                  put_idx = IDX_W'(pos_zb);
               end
            end
         end
         CMD_DEQUEUE: begin
            if (no_entries) begin
               status = ST_EMPTY;
            end else begin
               ctrl.take = req_fire;
               occ_in    = occ_ff - 1'b1;
            end
         end
         default: begin
            status = ST_DONE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_fill_in    = rsp_fill_ff;
      if (req_fire) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = status;
         rsp_removed_in = ctrl.take ? DATA_W'(cell_entry[0]) : '0;
         rsp_fill_in    = FILL_W'(occ_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            occ_ff <= occ_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_fill_ff    <= rsp_fill_in;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ENTRY_WIDTH-1:0] prev_entry;
      logic [ENTRY_WIDTH-1:0] next_entry;

      if (i == 0) begin : g_first
         assign prev_entry = new_entry;
      end else begin : g_mid_prev
         assign prev_entry = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_entry = cell_entry[i];
      end else begin : g_mid_next
         assign next_entry = cell_entry[i+1];
      end

      sqpi_cell #(
         .ENTRY_WIDTH (ENTRY_WIDTH),
         .IDX_W       (IDX_W),
         .INDEX       (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .put_idx    (put_idx),
         .new_entry  (new_entry),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (cell_entry[i])
      );
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.removed_data = rsp_removed_ff;
   assign rsp_chan.fill_count   = rsp_fill_ff;

endmodule

// ----- hw/rtl/sqpi_checker.sv -----
// ----------------------------------------------------------------------------
// sqpi_checker
// Port-level checks on the queue's command and result channels.
// ----------------------------------------------------------------------------
module sqpi_checker import sqpi_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [DATA_W-1:0]   rsp_removed_data,
   input logic [FILL_W-1:0]   rsp_fill_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result after command transfer");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("command taken while result stalled");

   a_full_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |->
         rsp_fill_count == FILL_W'(DEPTH) && rsp_removed_data == '0)
      else $error("full status with wrong fill or data");

   a_empty_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |->
         rsp_fill_count == '0 && rsp_removed_data == '0)
      else $error("empty status with wrong fill or data");

endmodule

bind shifting_queue_with_position_insert sqpi_checker #(
   .DEPTH (DEPTH)
) u_sqpi_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_removed_data (rsp_chan.removed_data),
   .rsp_fill_count   (rsp_chan.fill_count)
);

// ----- tb/sqpi_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// sqpi_tb_pkg
// Mirror of the shifting queue for the testbench. Each accepted command
// updates a copy of the queue and records the status, removed entry and fill
// count that the block must answer with. Each result transfer is then
// compared, in order, with the oldest recorded answer.
// ----------------------------------------------------------------------------
package sqpi_tb_pkg;
   import sqpi_pkg::*;

   // encoding the block must treat as a no-op
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      status_type            status;
      logic [DATA_W-1:0]     removed;
      logic [FILL_W-1:0]     fill;
   } queue_answer_type;

   class queue_mirror;
      logic [DATA_W-1:0] held[$];
      queue_answer_type  answers[$];
      int                mismatches;

      function new();
         mismatches = 0;
      endfunction

      function int fill();
         return held.size();
      endfunction

      function int pending();
         return answers.size();
      endfunction

      function void note_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] entry,
                                 logic [POSITION_W-1:0] position);
         queue_answer_type ans;
         int               slot;
         ans.status  = ST_DONE;
         ans.removed = '0;
         case (cmd)
            CMD_ENQUEUE, CMD_INSERT: begin
               if (held.size() >= DEPTH_DEF) begin
                  ans.status = ST_FULL;
               end else begin
                  slot = held.size();
                  if (cmd == CMD_INSERT) begin
                     // position 0 acts as 1; past the tail appends
                     slot = (position == 0) ? 0 : int'(position) - 1;
                     if (slot > held.size()) slot = held.size();
                  end
                  held.insert(slot, entry);
               end
            end
            CMD_DEQUEUE: begin
               if (held.size() == 0) ans.status = ST_EMPTY;
               else ans.removed = held.pop_front();
            end
            default: ;
         endcase
         ans.fill = FILL_W'(held.size());
         answers.push_back(ans);
      endfunction

      function void check_result(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] removed,
                                 logic [FILL_W-1:0] fill_count);
         queue_answer_type ans;
         if (answers.size() == 0) begin
            $display("%0t: unexpected result transfer: status %0d removed %h fill %0d",
                     $realtime, status, removed, fill_count);
            mismatches++;
            return;
         end
         ans = answers.pop_front();
         if (status !== ans.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $realtime, ans.status, status);
            mismatches++;
         end
         if (removed !== ans.removed) begin
            $display("%0t: removed_data mismatch: expected %h actual %h",
                     $realtime, ans.removed, removed);
            mismatches++;
         end
         if (fill_count !== ans.fill) begin
            $display("%0t: fill_count mismatch: expected %0d actual %0d",
                     $realtime, ans.fill, fill_count);
            mismatches++;
         end
      endfunction
   endclass

endpackage

// ----- tb/shifting_queue_with_position_insert_tb.sv -----
// ----------------------------------------------------------------------------
// shifting_queue_with_position_insert_tb
// Directed commands cover empty and full rejects, the unused command, insert
// at position zero, at the head, mid-queue and past the tail, and payload
// extremes. Random command streams then sweep the queue between empty and
// full under random stalls on both channels, one long result hold-off and
// one drain pause. Every result transfer is checked against the mirror.
// ----------------------------------------------------------------------------
module shifting_queue_with_position_insert_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sqpi_pkg::*;
   import sqpi_tb_pkg::*;

   localparam int RANDOM_ITEMS = 800;
   localparam int LONG_HOLD_AT = 300;
   localparam int DRAIN_AT     = 500;
   localparam int QUIET_AT     = 680;
   localparam int HOLD_CYCLES  = 60;
   localparam int CYCLE_LIMIT  = 200000;

   logic clock;
   logic reset;

   sqpi_req_if req_chan ();
   sqpi_rsp_if rsp_chan ();

   shifting_queue_with_position_insert dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   queue_mirror mirror = new();

   bit quiet;
   bit long_hold_req;
   int cycles;

   always #4 clock = ~clock;

   // timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         mirror.check_result(rsp_chan.status, rsp_chan.removed_data, rsp_chan.fill_count);
   end

   // result receiver: random stall bursts and one long hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      @(negedge clock);
      forever begin
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (long_hold_req) begin
            rsp_chan.ready <= 1'b0;
            stall_left = HOLD_CYCLES - 1;
            long_hold_req = 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = $urandom_range(1, 7) - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   task automatic send_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] entry,
                               logic [POSITION_W-1:0] position);
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= cmd;
      req_chan.entry_data <= entry;
      req_chan.position   <= position;
      do @(posedge clock); while (!req_chan.ready);
      mirror.note_command(cmd, entry, position);
      @(negedge clock);
   endtask

   task automatic idle_sender(int n);
      req_chan.valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic await_drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (mirror.pending() != 0);
   endtask

   function automatic logic [DATA_W-1:0] pick_entry();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [POSITION_W-1:0] pick_position(int fill);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return POSITION_W'($urandom_range(17, 31));
         default: return POSITION_W'($urandom_range(1, fill + 1));
      endcase
   endfunction

   initial begin
      logic [CMD_W-1:0] cmd;
      int               pick;
      int               fill;
      bit               filling;

      clock               = 1'b0;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.cmd        = CMD_ENQUEUE;
      req_chan.entry_data = '0;
      req_chan.position   = '0;
      rsp_chan.ready      = 1'b0;
      quiet               = 0;
      long_hold_req       = 0;
      cycles              = 0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed
      send_command(CMD_DEQUEUE, 32'h1234_5678, 5'd1);
      send_command(CMD_UNUSED, 32'hdead_beef, 5'd3);
      send_command(CMD_ENQUEUE, 32'h0000_0000, 5'd31);
      send_command(CMD_ENQUEUE, 32'hffff_ffff, 5'd0);
      send_command(CMD_INSERT, 32'ha5a5_a5a5, 5'd0);
      send_command(CMD_INSERT, 32'h5a5a_5a5a, 5'd1);
      send_command(CMD_INSERT, 32'h0f0f_0f0f, 5'd31);
      send_command(CMD_INSERT, 32'hf0f0_f0f0, 5'd2);
      send_command(CMD_DEQUEUE, 32'hffff_ffff, 5'd31);
      send_command(CMD_UNUSED, 32'h0000_0000, 5'd0);
      while (mirror.fill() < DEPTH_DEF)
         send_command(CMD_ENQUEUE, $urandom, 5'd0);
      send_command(CMD_ENQUEUE, 32'hffff_ffff, 5'd1);
      send_command(CMD_INSERT, 32'hffff_ffff, 5'd16);

      // random
      filling = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == LONG_HOLD_AT) long_hold_req = 1;
         if (n == DRAIN_AT) await_drain();
         if (n == QUIET_AT) quiet = 1;
         fill = mirror.fill();
         if (fill == DEPTH_DEF) filling = 0;
         else if (fill == 0) filling = 1;
         else if ($urandom_range(0, 39) == 0) filling = !filling;
         pick = $urandom_range(0, 99);
         if (pick < 4) cmd = CMD_UNUSED;
         else if (filling) cmd = (pick < 50) ? CMD_ENQUEUE : (pick < 85) ? CMD_INSERT : CMD_DEQUEUE;
         else cmd = (pick < 70) ? CMD_DEQUEUE : (pick < 85) ? CMD_ENQUEUE : CMD_INSERT;
         send_command(cmd, pick_entry(), pick_position(fill));
         if (!quiet && $urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 7));
      end

      req_chan.valid <= 1'b0;
      while (mirror.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mirror.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- shifting_queue_with_position_insert.f -----
hw/rtl/sqpi_pkg.sv
hw/rtl/sqpi_req_if.sv
hw/rtl/sqpi_rsp_if.sv
hw/rtl/sqpi_cell.sv
hw/rtl/shifting_queue_with_position_insert.sv
hw/rtl/sqpi_checker.sv
tb/sqpi_tb_pkg.sv
tb/shifting_queue_with_position_insert_tb.sv
